@@ sv/oaac_pkg.sv @@
package oaac_pkg;
    localparam int DEF_TABLE_SIZE = 1024;
    localparam logic [63:0] MIX_MULT = 64'hff51afd7ed558ccd;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_FORGET = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADKEY = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, first shift-xor
        logic mix_a;      // low 32x32 partial product
        logic mix_b;      // cross partial products into the upper word
        logic mix_c;      // final shift-xor, set probe index
        logic rd;         // issue slot read
        logic step;       // examine read data, advance index
        logic wr_put;     // write new / updated slot
        logic wr_tomb;    // turn hit slot into tombstone
        logic clr;        // clearing pass write
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       key_zero;
        logic       val_zero;
        logic       hit;      // live match in read data
        logic       empty;    // empty slot in read data
        logic       last;     // probe has covered the whole table
        logic       has_free;
        logic       full;     // used+1 threshold
        logic       clr_last;
    } t_sts;
endpackage

@@ sv/oaac_if.sv @@
interface oaac_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value;
    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface oaac_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] read_value;
    logic [1:0]  status;
    modport source (output valid, output found, output read_value, output status,
                    input ready);
    modport sink   (input valid, input found, input read_value, input status,
                    output ready);
endinterface

@@ sv/open_addressed_address_cache.sv @@
// Key-to-value cache over a linear-probed hash table of TABLE_SIZE slots.
// i_req (sink): op (0 get, 1 put, 2 forget), key, value; accepted when
// valid and ready are high at a clock edge. o_rsp (source): found,
// read_value, status (0 ok, 1 full, 2 invalid key), held until taken.
// One request at a time: the response is valid after the hash and P slot
// probes, where P is the number of slots probed (1 at low load, up to
// TABLE_SIZE). A new request is taken only once the last response has been
// taken. The single read port of the slot memory, one slot per probe, sets
// the probe pace; the hash runs load, mix_a, mix_b and mix_c, its 64-bit
// multiply split into two 32-bit register stages.
// After reset the marks are cleared one slot per cycle, with ready low
// until every slot is cleared. Keys and values are not cleared.
// When the receiver stalls the response holds and no new request is taken.
// put with value 0 acts as forget; new keys are refused once
// (used+1)*4 >= TABLE_SIZE*3 since tombstones stay counted until reset.
module open_addressed_address_cache
    import oaac_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    oaac_req_if.sink   i_req,
    oaac_rsp_if.source o_rsp
);
    t_cmd        cmd;
    t_sts        sts;
    logic [63:0] hit_value;
    logic        take_val;

    oaac_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_req.op),
        .i_key      (i_req.key),
        .i_value    (i_req.value),
        .o_sts      (sts),
        .o_hit_value(hit_value)
    );

    oaac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .o_found    (o_rsp.found),
        .o_status   (o_rsp.status),
        .o_take_val (take_val),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // read data stays put after a hit: no further reads until next request
    assign o_rsp.read_value = take_val ? hit_value : 64'd0;
endmodule

@@ sv/oaac_datapath.sv @@
module oaac_datapath
    import oaac_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    output t_sts        o_sts,
    output logic [63:0] o_hit_value
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam logic [CW+1:0] LIMIT = (CW+2)'(TABLE_SIZE * 3);

    logic [63:0] mem_key [TABLE_SIZE];
    logic [63:0] mem_val [TABLE_SIZE];
    logic [1:0]  mem_mark [TABLE_SIZE];

    logic [1:0]    r_op;
    logic [63:0]   r_key, r_val, r_x, r_prod;
    logic [AW-1:0] r_idx, r_free_at;
    logic [CW-1:0] r_cnt;
    logic          r_tomb_seen;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_live;
    logic [AW-1:0] r_clr;
    logic [63:0]   r_rd_key, r_rd_val;
    logic [1:0]    r_rd_mark;

    logic          rd_hit, rd_empty, free_is_empty;
    logic [AW-1:0] wr_at;
    logic [63:0]   mul_lo;
    logic [31:0]   mul_hl, mul_lh;

    assign rd_hit   = (r_rd_mark == MARK_LIVE) && (r_rd_key == r_key);
    assign rd_empty = (r_rd_mark == MARK_EMPTY);
    // a hit writes in place; else the first tombstone wins; otherwise the slot just examined
    assign free_is_empty = !r_tomb_seen && rd_empty;
    assign wr_at         = (rd_hit || !r_tomb_seen) ? r_idx : r_free_at;

    // 64-bit multiply as 32x32 pieces, only the low word is kept
    assign mul_lo = {32'd0, r_x[31:0]} * {32'd0, MIX_MULT[31:0]};
    assign mul_hl = r_x[63:32] * MIX_MULT[31:0];
    assign mul_lh = r_x[31:0] * MIX_MULT[63:32];

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key  <= mem_key[r_idx];
            r_rd_val  <= mem_val[r_idx];
            r_rd_mark <= mem_mark[r_idx];
        end
        if (i_cmd.clr) begin
            mem_mark[r_clr] <= MARK_EMPTY;
        end else if (i_cmd.wr_put) begin
            if (rd_hit) begin
                mem_val[wr_at] <= r_val;
            end else begin
                mem_key[wr_at]  <= r_key;
                mem_val[wr_at]  <= r_val;
                mem_mark[wr_at] <= MARK_LIVE;
            end
        end else if (i_cmd.wr_tomb) begin
            mem_mark[r_idx] <= MARK_TOMB;
            mem_val[r_idx]  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_value;
            r_x   <= i_key ^ (i_key >> 33);
        end
        if (i_cmd.mix_a) r_prod <= mul_lo;
        if (i_cmd.mix_b) r_x <= {r_prod[63:32] + mul_hl + mul_lh, r_prod[31:0]};
        if (i_cmd.mix_c) begin
            r_idx <= AW'(r_x ^ (r_x >> 29));
        end
        if (i_cmd.step) begin
            r_idx <= r_idx + AW'(1);
            if (r_rd_mark == MARK_TOMB && !r_tomb_seen) r_free_at <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_tomb_seen <= 1'b0;
            r_used      <= '0;
            r_live      <= '0;
            r_clr       <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.mix_c) begin
                r_cnt       <= '0;
                r_tomb_seen <= 1'b0;
            end
            if (i_cmd.step) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_rd_mark == MARK_TOMB) r_tomb_seen <= 1'b1;
            end
            if (i_cmd.wr_put && !rd_hit) begin
                r_live <= r_live + CW'(1);
                if (free_is_empty) r_used <= r_used + CW'(1);
            end
            if (i_cmd.wr_tomb && r_live != '0) r_live <= r_live - CW'(1);
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.key_zero = (r_key == '0);
        o_sts.val_zero = (r_val == '0);
        o_sts.hit      = rd_hit;
        o_sts.empty    = rd_empty;
        o_sts.last     = (r_cnt == CW'(TABLE_SIZE - 1));
        o_sts.has_free = r_tomb_seen || rd_empty || (r_rd_mark == MARK_TOMB);
        o_sts.full     = ({2'b00, r_used + CW'(1)} << 2) >= LIMIT;
        o_sts.clr_last = (r_clr == AW'(TABLE_SIZE - 1));
    end
    assign o_hit_value = r_rd_val;
endmodule

@@ sv/oaac_ctrl.sv @@
module oaac_ctrl
    import oaac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic        o_found,
    output logic [1:0]  o_status,
    output logic        o_take_val,
    input  t_sts        i_sts,
    output t_cmd        o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIX_A, S_MIX_B, S_MIX_C, S_READ, S_WAIT, S_CHECK, S_RESP
    } t_state;

    t_state     r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;
    logic       r_found, n_found;
    logic [1:0] r_status, n_status;
    logic       r_take_val, n_take_val;

    logic accept;
    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid;
    // a finished request may still be held while the next one waits

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_found     = r_found;
        n_status    = r_status;
        n_take_val  = r_take_val;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MIX_A;
                end
            end
            S_MIX_A: begin
                o_cmd.mix_a = 1'b1;
                n_state     = S_MIX_B;
            end
            S_MIX_B: begin
                o_cmd.mix_b = 1'b1;
                n_state     = S_MIX_C;
            end
            S_MIX_C: begin
                o_cmd.mix_c = 1'b1;
                n_found     = 1'b0;
                n_take_val  = 1'b0;
                n_status    = ST_OK;
                if (i_sts.op == OP_NONE) begin
                    n_state = S_RESP;
                end else if (i_sts.key_zero) begin
                    n_status = ST_BADKEY;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.step = 1'b1;
                n_state    = S_RESP;
                if (i_sts.hit) begin
                    if (i_sts.op == OP_GET) begin
                        n_found    = 1'b1;
                        n_take_val = 1'b1;
                    end else if (i_sts.op == OP_FORGET || i_sts.val_zero) begin
                        o_cmd.wr_tomb = 1'b1;
                    end else begin
                        o_cmd.wr_put = 1'b1;
                    end
                end else if (i_sts.empty || i_sts.last) begin
                    if (i_sts.op == OP_PUT && !i_sts.val_zero) begin
                        if (i_sts.full || !i_sts.has_free) n_status = ST_FULL;
                        else o_cmd.wr_put = 1'b1;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            S_RESP: begin
                n_rsp_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_status    <= ST_OK;
            r_take_val  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_found     <= n_found;
            r_status    <= n_status;
            r_take_val  <= n_take_val;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_found     = r_found;
    assign o_status    = r_status;
    assign o_take_val  = r_take_val;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_req_ready) else $error("accept during clear");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_found |-> o_status == ST_OK) else $error("found with bad status");
    a_one_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_put && o_cmd.wr_tomb)) else $error("double write");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid) else $error("response dropped");
endmodule
